FILE: rtl/wst_pkg.sv
// Shared constants, types and helpers for the weighted sample table.
// Used by wst_div and weighted_sample_table; no dependencies.
package wst_pkg;

  localparam int CAPACITY         = 64;
  localparam int WEIGHT_FRAC_BITS = 24;
  localparam int RANDOM_BITS      = 16;

  localparam int IDX_W   = 6;                      // slot_index / slot_out / pick_count
  localparam int CNT_W   = 7;                      // entry_count, holds CAPACITY itself
  localparam int W_W     = 32;                     // weight and handle width
  localparam int TOTAL_W = 38;                     // running total
  localparam int DVD_W   = W_W + WEIGHT_FRAC_BITS; // normalize dividend
  localparam int DIV_CW  = $clog2(DVD_W);
  localparam int HALF_W  = TOTAL_W / 2;            // sample multiply split point
  localparam int X_W     = RANDOM_BITS + TOTAL_W;  // scaled threshold
  localparam int KEY_W   = W_W + IDX_W;            // (weight, slot) order key

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 72;

  localparam logic [W_W-1:0] WEIGHT_ONE = W_W'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [3:0] {
    ACT_ADD_DEF  = 4'd0,
    ACT_ADD_W    = 4'd1,
    ACT_REP_DEF  = 4'd2,
    ACT_REP_W    = 4'd3,
    ACT_RELEASE  = 4'd4,
    ACT_READ     = 4'd5,
    ACT_SAMPLE   = 4'd6,
    ACT_NORM_SUM = 4'd7,
    ACT_NORM_GIV = 4'd8,
    ACT_LEAST    = 4'd9,
    ACT_CLEAR    = 4'd10
  } act_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BAD_IDX = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BAD_CNT = 3'd4
  } sts_e;

  typedef struct packed {
    sts_e             status;
    logic [IDX_W-1:0] slot;
    logic [W_W-1:0]   handle;
    logic [W_W-1:0]   weight;
    logic             last;
  } res_t;

  function automatic res_t mk_res(input sts_e st, input logic [IDX_W-1:0] slot,
                                  input logic [W_W-1:0] h, input logic [W_W-1:0] w,
                                  input logic last);
    res_t r;
    r.status = st;
    r.slot   = slot;
    r.handle = h;
    r.weight = w;
    r.last   = last;
    return r;
  endfunction

  function automatic logic [W_W-1:0] sat32(input logic [DVD_W-1:0] v);
    logic [W_W-1:0] r;
    r = (|v[DVD_W-1:W_W]) ? '1 : v[W_W-1:0];
    return r;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_tot(input logic [TOTAL_W:0] v);
    logic [TOTAL_W-1:0] r;
    r = v[TOTAL_W] ? '1 : v[TOTAL_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/wst_div.sv
// Restoring divider, one quotient bit per cycle over a DVD_W-bit dividend.
// Depends on wst_pkg. Divisor must be nonzero.
module wst_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wst_pkg::DVD_W-1:0]    dividend_i,
  input  logic [wst_pkg::TOTAL_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [wst_pkg::DVD_W-1:0]    quot_o
);

  logic                         busy_q, done_q;
  logic [wst_pkg::DIV_CW-1:0]   step_q;
  logic [wst_pkg::TOTAL_W-1:0]  rem_q, dvs_q;
  logic [wst_pkg::DVD_W-1:0]    quo_q;
  logic [wst_pkg::TOTAL_W:0]    shl;
  logic                         fit;

  // partial remainder stays below the divisor, so one spare bit is enough
  assign shl = {rem_q, quo_q[wst_pkg::DVD_W-1]};
  assign fit = shl >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= wst_pkg::DIV_CW'(wst_pkg::DVD_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fit ? wst_pkg::TOTAL_W'(shl - {1'b0, dvs_q}) : shl[wst_pkg::TOTAL_W-1:0];
      quo_q <= {quo_q[wst_pkg::DVD_W-2:0], fit};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  property p_start_idle;
    @(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("divider restarted while busy");

endmodule

FILE: rtl/weighted_sample_table.sv
// Weighted sample table: handles with Q8.24 weights and a saturating running total.
// Depends on wst_pkg and wst_div.
//
// Usage: one command beat enters on the s_axis channel (action in tuser, operands in
// tdata); results leave on m_axis, tlast on the final result of the command. The block
// works on one command at a time; s_axis_tready is high only while it waits for one.
// Per-command flow (N = entry count):
//   add weighted, replace weighted, release, read, clear on empty: one result
//   add default on a nonempty table, replace default: wait for the divider first
//   sample: one entry per cycle walking down from the last entry
//   normalize: the divider serves one entry at a time
//   least likely (n): 2n - 1 passes over the weight memory
//   clear: one result per cycle while the receiver takes them, N beats
// Entries live in two 64x32 synchronous memories (weight, handle), one read and one
// write port, read data registered. Reset clears the entry count and total, not the memories; the
// memories are never swept, entries past the count are never read.
// Results go through an output register: a stalled receiver holds the beat, and
// multi-beat commands pause until it is taken.
module weighted_sample_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [5:0] slot_index, [37:6] handle_in, [69:38] weight_in,
  // [85:70] random_fraction, [91:86] pick_count, [95:92] zero
  input  logic [wst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [3:0] action
  input  logic [3:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] slot_out, [37:6] handle_out, [69:38] weight_out, [71:70] zero
  output logic [wst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [2:0] status
  output logic [2:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int IW = wst_pkg::IDX_W;
  localparam int CW = wst_pkg::CNT_W;
  localparam int WW = wst_pkg::W_W;
  localparam int TW = wst_pkg::TOTAL_W;
  localparam int RB = wst_pkg::RANDOM_BITS;
  localparam int HW = wst_pkg::HALF_W;
  localparam int XW = wst_pkg::X_W;
  localparam int KW = wst_pkg::KEY_W;
  localparam int DW = wst_pkg::DVD_W;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_DIVW, S_ADD, S_REP, S_SM1, S_SM2, S_SMW, S_SMF,
    S_SUM, S_NRD, S_NWT, S_NDN, S_LLS, S_LLP, S_LLE, S_CLR, S_ONE
  } state_e;

  state_e state_q, state_d;

  logic [3:0]    act_q, act_d;
  logic [IW-1:0] idx_q, idx_d, pick_q, pick_d;
  logic [WW-1:0] hin_q, hin_d, win_q, win_d;
  logic [RB-1:0] rnd_q, rnd_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] total_q, total_d;
  logic [IW-1:0] addr_q, addr_d;
  logic [WW-1:0] nw_q, nw_d;
  logic [TW-1:0] acc_q, acc_d, dvs_q, dvs_d, rem_q, rem_d;
  logic [RB+HW-1:0] prod_q, prod_d;
  logic [XW-1:0] x_q, x_d;

  // least-likely selection
  logic [IW-1:0] pc_q, pc_d, em_q, em_d;
  logic          dir_q, dir_d, bnd_v_q, bnd_v_d, best_v_q, best_v_d;
  logic [KW-1:0] bnd_q, bnd_d, best_q, best_d;
  logic [WW-1:0] best_h_q, best_h_d;

  wst_pkg::res_t pend_q, pend_d, out_q, out_d;
  logic          out_v_q, out_v_d;

  // memories
  logic [WW-1:0] weight_mem [wst_pkg::CAPACITY];
  logic [WW-1:0] handle_mem [wst_pkg::CAPACITY];
  logic [WW-1:0] rdw_q, rdh_q;
  logic          wm_we, hm_we;
  logic [IW-1:0] mem_wa;
  logic [WW-1:0] wm_wd, hm_wd;

  // divider
  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_dvd, div_quot;
  logic [TW-1:0] div_dvs;

  logic          accept, out_free, last_addr, smp_hit, bad_idx;
  logic [TW-1:0] rem_n, tot_less, sum_n;
  logic [KW-1:0] ll_key;
  logic          ll_in, ll_better;
  logic [XW-HW-1:0] mhi;
  logic [RB+HW-1:0] mlo;
  logic [TW-1:0] thr;

  wst_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_v_q || m_axis_tready;
  assign last_addr = ({1'b0, addr_q} == (cnt_q - 1'b1));
  assign bad_idx   = ({1'b0, idx_q} >= cnt_q);

  assign rem_n    = (rem_q > TW'(rdw_q)) ? rem_q - TW'(rdw_q) : '0;
  assign tot_less = (total_q > TW'(rdw_q)) ? total_q - TW'(rdw_q) : '0;
  assign sum_n    = acc_q + TW'(rdw_q);

  // threshold = floor(r * total / 2^RB); fractional part breaks ties
  assign thr     = x_q[XW-1:RB];
  assign smp_hit = (thr > rem_n) || ((thr == rem_n) && (|x_q[RB-1:0]));

  assign mlo = rnd_q * total_q[HW-1:0];
  assign mhi = rnd_q * total_q[TW-1:HW];

  assign ll_key    = {rdw_q, addr_q};
  assign ll_in     = dir_q ? (ll_key < bnd_q) : (!bnd_v_q || (ll_key > bnd_q));
  assign ll_better = !best_v_q || (dir_q ? (ll_key > best_q) : (ll_key < best_q));

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    idx_d    = idx_q;
    pick_d   = pick_q;
    hin_d    = hin_q;
    win_d    = win_q;
    rnd_d    = rnd_q;
    cnt_d    = cnt_q;
    total_d  = total_q;
    addr_d   = addr_q;
    nw_d     = nw_q;
    acc_d    = acc_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    prod_d   = prod_q;
    x_d      = x_q;
    pc_d     = pc_q;
    em_d     = em_q;
    dir_d    = dir_q;
    bnd_v_d  = bnd_v_q;
    bnd_d    = bnd_q;
    best_v_d = best_v_q;
    best_d   = best_q;
    best_h_d = best_h_q;
    pend_d   = pend_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !m_axis_tready;

    wm_we  = 1'b0;
    hm_we  = 1'b0;
    mem_wa = addr_q;
    wm_wd  = nw_q;
    hm_wd  = hin_q;

    div_start = 1'b0;
    div_dvd   = DW'(total_q);
    div_dvs   = TW'(cnt_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d   = s_axis_tuser;
          idx_d   = s_axis_tdata[5:0];
          hin_d   = s_axis_tdata[37:6];
          win_d   = s_axis_tdata[69:38];
          rnd_d   = s_axis_tdata[85:70];
          pick_d  = s_axis_tdata[91:86];
          addr_d  = s_axis_tdata[5:0];
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        state_d = S_ONE;
        unique case (wst_pkg::act_e'(act_q))
          wst_pkg::ACT_ADD_DEF, wst_pkg::ACT_ADD_W: begin
            if (cnt_q >= CW'(wst_pkg::CAPACITY)) begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_FULL, '0, '0, '0, 1'b1);
            end else if (act_q == wst_pkg::ACT_ADD_W) begin
              nw_d    = win_q;
              state_d = S_ADD;
            end else if (cnt_q == '0) begin
              // first add on an empty table gets weight 1.0
              nw_d    = (total_q == '0) ? wst_pkg::WEIGHT_ONE : '0;
              state_d = S_ADD;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIVW;
            end
          end
          wst_pkg::ACT_REP_DEF, wst_pkg::ACT_REP_W: begin
            if (bad_idx) begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_BAD_IDX, '0, '0, '0, 1'b1);
            end else if (act_q == wst_pkg::ACT_REP_W) begin
              nw_d    = win_q;
              state_d = S_REP;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIVW;
            end
          end
          wst_pkg::ACT_RELEASE, wst_pkg::ACT_READ: begin
            if (bad_idx) begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_BAD_IDX, '0, '0, '0, 1'b1);
            end else begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_OK, idx_q, rdh_q, rdw_q, 1'b1);
              if (act_q == wst_pkg::ACT_RELEASE) begin
                hm_we  = 1'b1;
                mem_wa = idx_q;
                hm_wd  = '0;
              end
            end
          end
          wst_pkg::ACT_SAMPLE: begin
            if (cnt_q == '0 || total_q == '0) begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
            end else begin
              state_d = S_SM1;
            end
          end
          wst_pkg::ACT_NORM_SUM: begin
            acc_d = '0;
            if (cnt_q == '0) begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
            end else begin
              addr_d  = '0;
              state_d = S_SUM;
            end
          end
          wst_pkg::ACT_NORM_GIV: begin
            acc_d = '0;
            dvs_d = TW'(win_q);
            if (win_q == '0) begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
            end else if (cnt_q == '0) begin
              state_d = S_NDN;
            end else begin
              addr_d  = '0;
              state_d = S_NRD;
            end
          end
          wst_pkg::ACT_LEAST: begin
            if ({1'b0, pick_q} >= cnt_q) begin
              pend_d = wst_pkg::mk_res(wst_pkg::ST_BAD_CNT, '0, '0, '0, 1'b1);
            end else if (pick_q == '0) begin
              state_d = S_IDLE;
            end else begin
              pc_d     = pick_q;
              em_d     = pick_q;
              dir_d    = 1'b0;
              bnd_v_d  = 1'b0;
              best_v_d = 1'b0;
              addr_d   = '0;
              state_d  = S_LLS;
            end
          end
          wst_pkg::ACT_CLEAR: begin
            if (cnt_q == '0) begin
              total_d = '0;
              pend_d  = wst_pkg::mk_res(wst_pkg::ST_OK, '0, '0, '0, 1'b1);
            end else begin
              addr_d  = '0;
              state_d = S_CLR;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_DIVW: begin
        if (div_done) begin
          nw_d    = wst_pkg::sat32(div_quot);
          state_d = (act_q == wst_pkg::ACT_ADD_DEF) ? S_ADD : S_REP;
        end
      end

      S_ADD: begin
        wm_we   = 1'b1;
        hm_we   = 1'b1;
        mem_wa  = cnt_q[IW-1:0];
        cnt_d   = cnt_q + 1'b1;
        total_d = wst_pkg::sat_tot({1'b0, total_q} + (TW + 1)'(nw_q));
        pend_d  = wst_pkg::mk_res(wst_pkg::ST_OK, cnt_q[IW-1:0], hin_q, nw_q, 1'b1);
        state_d = S_ONE;
      end

      S_REP: begin
        // read data still holds the old entry at idx
        wm_we   = 1'b1;
        hm_we   = 1'b1;
        mem_wa  = idx_q;
        total_d = wst_pkg::sat_tot({1'b0, tot_less} + (TW + 1)'(nw_q));
        pend_d  = wst_pkg::mk_res(wst_pkg::ST_OK, idx_q, rdh_q, nw_q, 1'b1);
        state_d = S_ONE;
      end

      S_SM1: begin
        prod_d  = mlo;
        state_d = S_SM2;
      end

      S_SM2: begin
        x_d     = {mhi, HW'(0)} + XW'(prod_q);
        rem_d   = total_q;
        addr_d  = IW'(cnt_q - 1'b1);
        state_d = (cnt_q == CW'(1)) ? S_SMF : S_SMW;
      end

      S_SMW: begin
        if (smp_hit) begin
          pend_d  = wst_pkg::mk_res(wst_pkg::ST_OK, addr_q, rdh_q, rdw_q, 1'b1);
          state_d = S_ONE;
        end else if (addr_q == IW'(1)) begin
          addr_d  = '0;
          state_d = S_SMF;
        end else begin
          rem_d  = rem_n;
          addr_d = addr_q - 1'b1;
        end
      end

      S_SMF: begin
        pend_d  = wst_pkg::mk_res(wst_pkg::ST_OK, '0, rdh_q, rdw_q, 1'b1);
        state_d = S_ONE;
      end

      S_SUM: begin
        acc_d = sum_n;
        if (last_addr) begin
          if (sum_n == '0) begin
            pend_d  = wst_pkg::mk_res(wst_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
            state_d = S_ONE;
          end else begin
            dvs_d   = sum_n;
            acc_d   = '0;
            addr_d  = '0;
            state_d = S_NRD;
          end
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      S_NRD: begin
        div_start = 1'b1;
        div_dvd   = {rdw_q, wst_pkg::WEIGHT_FRAC_BITS'(0)};
        div_dvs   = dvs_q;
        state_d   = S_NWT;
      end

      S_NWT: begin
        if (div_done) begin
          wm_we  = 1'b1;
          wm_wd  = wst_pkg::sat32(div_quot);
          acc_d  = wst_pkg::sat_tot({1'b0, acc_q} + (TW + 1)'(wst_pkg::sat32(div_quot)));
          if (last_addr) begin
            state_d = S_NDN;
          end else begin
            addr_d  = addr_q + 1'b1;
            state_d = S_NRD;
          end
        end
      end

      S_NDN: begin
        total_d = acc_q;
        pend_d  = wst_pkg::mk_res(wst_pkg::ST_OK, '0, '0, wst_pkg::sat32(DW'(acc_q)), 1'b1);
        state_d = S_ONE;
      end

      // one pass over the table: next key above (ascending) or below (descending) bound
      S_LLS: begin
        if (ll_in && ll_better) begin
          best_d   = ll_key;
          best_h_d = rdh_q;
          best_v_d = 1'b1;
        end
        if (last_addr) begin
          state_d = S_LLP;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end

      S_LLP: begin
        if (dir_q || pc_q == IW'(1)) begin
          state_d = S_LLE;
        end else begin
          pc_d     = pc_q - 1'b1;
          bnd_d    = best_q;
          bnd_v_d  = 1'b1;
          best_v_d = 1'b0;
          addr_d   = '0;
          state_d  = S_LLS;
        end
      end

      S_LLE: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = wst_pkg::mk_res(wst_pkg::ST_OK, best_q[IW-1:0], best_h_q,
                                    best_q[KW-1:IW], em_q == IW'(1));
          if (em_q == IW'(1)) begin
            state_d = S_IDLE;
          end else begin
            em_d     = em_q - 1'b1;
            bnd_d    = best_q;
            bnd_v_d  = 1'b1;
            best_v_d = 1'b0;
            dir_d    = 1'b1;
            addr_d   = '0;
            state_d  = S_LLS;
          end
        end
      end

      S_CLR: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = wst_pkg::mk_res(wst_pkg::ST_OK, addr_q, rdh_q, rdw_q, last_addr);
          if (last_addr) begin
            cnt_d   = '0;
            total_d = '0;
            state_d = S_IDLE;
          end else begin
            addr_d = addr_q + 1'b1;
          end
        end
      end

      S_ONE: begin
        if (out_free) begin
          out_v_d = 1'b1;
          out_d   = pend_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      total_q  <= '0;
      out_v_q  <= 1'b0;
      act_q    <= '0;
      idx_q    <= '0;
      pick_q   <= '0;
      hin_q    <= '0;
      win_q    <= '0;
      rnd_q    <= '0;
      addr_q   <= '0;
      nw_q     <= '0;
      acc_q    <= '0;
      dvs_q    <= '0;
      rem_q    <= '0;
      prod_q   <= '0;
      x_q      <= '0;
      pc_q     <= '0;
      em_q     <= '0;
      dir_q    <= 1'b0;
      bnd_v_q  <= 1'b0;
      bnd_q    <= '0;
      best_v_q <= 1'b0;
      best_q   <= '0;
      best_h_q <= '0;
      pend_q   <= '0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      out_v_q  <= out_v_d;
      act_q    <= act_d;
      idx_q    <= idx_d;
      pick_q   <= pick_d;
      hin_q    <= hin_d;
      win_q    <= win_d;
      rnd_q    <= rnd_d;
      addr_q   <= addr_d;
      nw_q     <= nw_d;
      acc_q    <= acc_d;
      dvs_q    <= dvs_d;
      rem_q    <= rem_d;
      prod_q   <= prod_d;
      x_q      <= x_d;
      pc_q     <= pc_d;
      em_q     <= em_d;
      dir_q    <= dir_d;
      bnd_v_q  <= bnd_v_d;
      bnd_q    <= bnd_d;
      best_v_q <= best_v_d;
      best_q   <= best_d;
      best_h_q <= best_h_d;
      pend_q   <= pend_d;
      out_q    <= out_d;
    end
  end

  // read address is the next-state address, so rd*_q always matches addr_q
  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      weight_mem[mem_wa] <= wm_wd;
    end
    rdw_q <= weight_mem[addr_d];
  end

  always_ff @(posedge clk_i) begin
    if (hm_we) begin
      handle_mem[mem_wa] <= hm_wd;
    end
    rdh_q <= handle_mem[addr_d];
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_q.weight, out_q.handle, out_q.slot};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(wst_pkg::CAPACITY);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("entry count over capacity");

  property p_empty_total;
    @(posedge clk_i) disable iff (!rst_ni) (cnt_q == '0) |-> (total_q == '0);
  endproperty
  a_empty_total: assert property (p_empty_total) else $error("empty table with nonzero total");

  property p_accept_dec;
    @(posedge clk_i) disable iff (!rst_ni) accept |=> (state_q == S_DEC);
  endproperty
  a_accept_dec: assert property (p_accept_dec) else $error("command beat not decoded");

  property p_div_wait;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_DIVW || state_q == S_NWT) && !div_done |-> div_busy;
  endproperty
  a_div_wait: assert property (p_div_wait) else $error("waiting on idle divider");

endmodule
